[hdl/rau_pkg.sv]
// rau_pkg: shared types and constants for the rational arithmetic unit.
// Used by rau_div and rational_arithmetic_unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

  localparam int unsigned OperW = 16;  // operand numerator / denominator width
  localparam int unsigned ProdW = 32;  // one cross product
  localparam int unsigned NumW  = 33;  // result numerator, also divider operand width
  localparam int unsigned DenW  = 32;  // result denominator

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } rau_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } rau_status_e;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;  // one-cycle pulse, quotient and remainder valid
  } rau_div_stat_t;

endpackage

`default_nettype wire

[hdl/rau_div.sv]
// rau_div: iterative signed divider, one quotient bit per cycle, C truncation.
// Depends on rau_pkg (widths, rau_div_stat_t).
`timescale 1ns / 1ps
`default_nettype none

module rau_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [rau_pkg::NumW-1:0]       dividend_i,
  input  logic signed [rau_pkg::NumW-1:0]       divisor_i,
  output rau_pkg::rau_div_stat_t                stat_o,
  output logic signed [rau_pkg::NumW-1:0]       quot_o,
  output logic signed [rau_pkg::NumW-1:0]       rem_o
);
  import rau_pkg::*;

  localparam int unsigned MagW = NumW - 1;
  localparam int unsigned CntW = $clog2(MagW);
  localparam logic [CntW-1:0] LastCnt = CntW'(MagW - 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [MagW-1:0] quo_q, rem_q, dvs_q;
  logic            negq_q, negr_q;

  logic [NumW-1:0] dvd_abs, dvs_abs;
  logic [MagW:0]   rem_sh, diff;
  logic            ge;
  logic [MagW-1:0] rem_nx;

  // magnitudes never reach 2^MagW here, so the low bits suffice
  assign dvd_abs = dividend_i[NumW-1] ? (-dividend_i) : dividend_i;
  assign dvs_abs = divisor_i[NumW-1]  ? (-divisor_i)  : divisor_i;

  // restoring step
  assign rem_sh = {rem_q, quo_q[MagW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = (rem_sh >= {1'b0, dvs_q});
  assign rem_nx = ge ? diff[MagW-1:0] : rem_sh[MagW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= dvd_abs[MagW-1:0];
        rem_q  <= '0;
        dvs_q  <= dvs_abs[MagW-1:0];
        negq_q <= dividend_i[NumW-1] ^ divisor_i[NumW-1];
        negr_q <= dividend_i[NumW-1];
      end else if (busy_q) begin
        quo_q <= {quo_q[MagW-2:0], ge};
        rem_q <= rem_nx;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quot_o = negq_q ? (-{1'b0, quo_q}) : {1'b0, quo_q};
  assign rem_o  = negr_q ? (-{1'b0, rem_q}) : {1'b0, rem_q};

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("divider done without a run");

  a_rem_below : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

[hdl/rational_arithmetic_unit.sv]
// rational_arithmetic_unit: fraction add/sub/mul/div with optional Euclid reduction.
// Depends on rau_pkg and rau_div.
//
//  channel | dir | tdata (low bit up)                       | tuser (low bit up)
//  s_axis  | in  | a_num[15:0] a_den[31:16] b_num[47:32]     | command[1:0] reduce[2]
//          |     | b_den[63:48]                             |
//  m_axis  | out | result_num[32:0] result_den[64:33] 0s    | status[1:0]
//
// Sequencing: one beat is taken only when the sequencer is idle. The three cross
// products run in turn on one shared 16x16 multiplier, then the sum is formed, then
// done. With reduce set, every Euclid remainder step and the two final divisions
// each take one pass of the shared divider; error items go straight to done.
// Reset clears the sequencer and the output valid; payload registers are not reset.
// The output register frees the input side: a new beat may be taken while the
// previous result still waits on m_axis_tready.
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // a_numerator, a_denominator, b_numerator, b_denominator
  input  logic [2:0]  s_axis_tuser,   // command[1:0], reduce[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // result_numerator[32:0], result_denominator[64:33], pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import rau_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_EUC,
    S_QN,
    S_QD,
    S_DONE
  } state_e;

  state_e                   state_q;
  logic [1:0]               cnt_q;
  rau_op_e                  op_q;
  logic                     red_q;
  logic signed [OperW-1:0]  an_q, ad_q, bn_q, bd_q;
  logic signed [ProdW-1:0]  p0_q, p1_q;
  logic signed [NumW-1:0]   n_q;
  logic signed [DenW-1:0]   d_q;
  rau_status_e              st_q;

  // divider interface, registered
  logic                     div_start_q;
  logic signed [NumW-1:0]   div_a_q, div_b_q;
  rau_div_stat_t            div_stat;
  logic signed [NumW-1:0]   div_quot, div_rem;

  // output register
  logic                     out_valid_q;
  logic signed [NumW-1:0]   out_num_q;
  logic signed [DenW-1:0]   out_den_q;
  rau_status_e              out_st_q;

  // input unpacking
  rau_op_e                  in_op;
  logic signed [OperW-1:0]  in_an, in_ad, in_bn, in_bd;

  assign in_op = rau_op_e'(s_axis_tuser[1:0]);
  assign in_an = s_axis_tdata[15:0];
  assign in_ad = s_axis_tdata[31:16];
  assign in_bn = s_axis_tdata[47:32];
  assign in_bd = s_axis_tdata[63:48];

  // shared multiplier: operand pair chosen by step and operation
  logic signed [OperW-1:0] mul_x, mul_y;
  logic signed [ProdW-1:0] prod;

  always_comb begin
    mul_x = ad_q;
    mul_y = bd_q;
    case (cnt_q)
      2'd0: begin
        mul_x = an_q;
        mul_y = (op_q == OP_MUL) ? bn_q : bd_q;
      end
      2'd1: begin
        mul_x = ad_q;
        mul_y = bn_q;
      end
      default: begin
        mul_x = ad_q;
        mul_y = (op_q == OP_DIV) ? bn_q : bd_q;
      end
    endcase
  end

  assign prod = mul_x * mul_y;

  // numerator: sum or difference of the two stored products, or the first alone for mul/div
  logic signed [NumW-1:0] p0_ext, p1_ext, n_sum;

  assign p0_ext = {p0_q[ProdW-1], p0_q};
  assign p1_ext = {p1_q[ProdW-1], p1_q};

  always_comb begin
    case (op_q)
      OP_ADD:  n_sum = p0_ext + p1_ext;
      OP_SUB:  n_sum = p0_ext - p1_ext;
      default: n_sum = p0_ext;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      // S_DONE refills the output register itself
      if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q  <= in_op;
            red_q <= s_axis_tuser[2];
            an_q  <= in_an;
            ad_q  <= in_ad;
            bn_q  <= in_bn;
            bd_q  <= in_bd;
            cnt_q <= '0;
            if (in_ad == '0 || in_bd == '0) begin
              n_q     <= '0;
              d_q     <= DenW'(1);
              st_q    <= ST_ZERO_DEN;
              state_q <= S_DONE;
            end else if (in_op == OP_DIV && in_bn == '0) begin
              n_q     <= '0;
              d_q     <= DenW'(1);
              st_q    <= ST_DIV_ZERO;
              state_q <= S_DONE;
            end else begin
              st_q    <= ST_OK;
              state_q <= S_MUL;
            end
          end
        end

        S_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          case (cnt_q)
            2'd0:    p0_q <= prod;
            2'd1:    p1_q <= prod;
            default: begin
              d_q     <= prod;
              state_q <= S_SUM;
            end
          endcase
        end

        S_SUM: begin
          n_q <= n_sum;
          if (red_q) begin
            div_a_q     <= n_sum;
            div_b_q     <= {d_q[DenW-1], d_q};
            div_start_q <= 1'b1;
            state_q     <= S_EUC;
          end else begin
            state_q <= S_DONE;
          end
        end

        // x <- y, y <- x rem y until the remainder is zero; g is left in div_b_q
        S_EUC: begin
          if (div_stat.done) begin
            div_start_q <= 1'b1;
            if (div_rem == '0) begin
              div_a_q <= n_q;
              state_q <= S_QN;
            end else begin
              div_a_q <= div_b_q;
              div_b_q <= div_rem;
            end
          end
        end

        S_QN: begin
          if (div_stat.done) begin
            n_q         <= div_quot;
            div_a_q     <= {d_q[DenW-1], d_q};
            div_start_q <= 1'b1;
            state_q     <= S_QD;
          end
        end

        S_QD: begin
          if (div_stat.done) begin
            d_q     <= div_quot[DenW-1:0];
            state_q <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_num_q   <= n_q;
            out_den_q   <= d_q;
            out_st_q    <= st_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_den_q, out_num_q};
  assign m_axis_tuser  = out_st_q;

  a_err_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q != ST_OK) |-> (out_num_q == '0 && out_den_q == DenW'(1)))
    else $error("error result carries a non-trivial fraction");

  a_ok_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q == ST_OK) |-> (out_den_q != '0))
    else $error("good result with zero denominator");

  a_div_only_reduce : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == S_EUC || state_q == S_QN || state_q == S_QD))
    else $error("divider running outside reduction");

  a_no_zero_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> (div_b_q != '0))
    else $error("divider started with zero divisor");

endmodule

`default_nettype wire
